[src/alc_pkg.sv]
// alc_pkg: constants, codes and shared types of the aging lru dirty line cleaner
// used by alc_list_regs, the top level and alc_checker, depends on nothing
`default_nettype none
package alc_pkg;

	localparam int LINES    = 4096;
	localparam int PARTS    = 32;
	localparam int LINE_W   = $clog2(LINES);
	localparam int LINK_W   = LINE_W + 1;
	localparam int PIDX_W   = (PARTS > 1) ? $clog2(PARTS) : 1;
	localparam int PCNT_W   = $clog2(PARTS + 1);
	localparam int MAX_EMIT = 64;
	localparam int LIM_W    = 7;
	localparam int ADDR_W   = 4;

	localparam logic [LINK_W-1:0] TERM = LINK_W'(LINES);

	typedef enum logic [1:0] {
		OP_SET_HOT = 2'd0,
		OP_PURGE   = 2'd1,
		OP_COLLECT = 2'd2,
		OP_RSVD    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED     = 3'd0,
		ST_REMOVED      = 3'd1,
		ST_NOT_LISTED   = 3'd2,
		ST_FLUSH_LINE   = 3'd3,
		ST_IO_BUSY      = 3'd4,
		ST_TOO_SOON     = 3'd5,
		ST_DISABLED     = 3'd6,
		ST_NOTHING_AGED = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_WAKEUP    = 2'd0,
		REG_STALENESS = 2'd1,
		REG_LIMIT     = 2'd2,
		REG_ACTIVITY  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t         operation;
		logic [11:0] line;
		logic [4:0]  partition;
		logic [31:0] now_seconds;
		logic [31:0] idle_ms;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] flush_line;
		logic [4:0]  flush_partition;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [PIDX_W-1:0] owner;
		logic [LINK_W-1:0] next;
		logic [LINK_W-1:0] prev;
		logic [31:0]       stamp;
	} link_word_t;

	typedef struct packed {
		logic [PIDX_W-1:0] idx;
		logic              head_we;
		logic              tail_we;
		logic              inc;
		logic              dec;
		logic [LINK_W-1:0] val;
	} list_cmd_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_CHK,
		S_UL_PR,
		S_UL_PW,
		S_UL_NR,
		S_UL_NW,
		S_UL_FIN,
		S_INS_L,
		S_INS_HR,
		S_INS_HW,
		S_GATE_WAKE,
		S_GATE_CMP,
		S_CUT,
		S_WALK_T,
		S_WALK_RD,
		S_WALK_CHK,
		S_FINISH
	} state_t;

endpackage
`default_nettype wire

[src/alc_ram.sv]
// alc_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module alc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[src/alc_alu.sv]
// alc_alu: shared 32 bit subtract and unsigned compare unit
// no dependencies
`default_nettype none
module alc_alu (
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output      logic [31:0] diff,
	output      logic        lt
);
	logic [32:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};
	assign diff = wide[31:0];
	assign lt   = wide[32];
endmodule
`default_nettype wire

[src/alc_list_regs.sv]
// alc_list_regs: per partition head, tail and count registers, one index per cycle
// depends on alc_pkg
`default_nettype none
module alc_list_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire alc_pkg::list_cmd_t            cmd,
	output      logic [alc_pkg::LINK_W-1:0]    head,
	output      logic [alc_pkg::LINK_W-1:0]    tail
);
	logic [alc_pkg::LINK_W-1:0] head_q  [alc_pkg::PARTS];
	logic [alc_pkg::LINK_W-1:0] tail_q  [alc_pkg::PARTS];
	logic [alc_pkg::LINK_W-1:0] count_q [alc_pkg::PARTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < alc_pkg::PARTS; i++) begin
				head_q[i]  <= alc_pkg::TERM;
				tail_q[i]  <= alc_pkg::TERM;
				count_q[i] <= '0;
			end
		end else begin
			if (cmd.head_we) begin
				head_q[cmd.idx] <= cmd.val;
			end
			if (cmd.tail_we) begin
				tail_q[cmd.idx] <= cmd.val;
			end
			if (cmd.inc) begin
				count_q[cmd.idx] <= count_q[cmd.idx] + 1'b1;
			end else if (cmd.dec && count_q[cmd.idx] != '0) begin
				count_q[cmd.idx] <= count_q[cmd.idx] - 1'b1;
			end
		end
	end

	assign head = head_q[cmd.idx];
	assign tail = tail_q[cmd.idx];
endmodule
`default_nettype wire

[src/aging_lru_dirty_line_cleaner.sv]
// aging_lru_dirty_line_cleaner: top level, sequencer around the link ram,
// the list registers and the shared subtract/compare unit
// depends on alc_pkg, alc_ram, alc_alu, alc_list_regs
//
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  alc_pkg::req_t
// rsp      out        rsp_valid/rsp_stall  alc_pkg::rsp_t
// apb      in         psel/penable/pready  paddr, pwdata, prdata
//
// set_hot, purge and collect items are sequenced around the single port of the link ram
// and the shared compare unit; a collect pass reads each line it examines, then compares it.
// every item ends back in the idle state, where the next req transfer is taken.
// after reset a clearing pass sweeps every line of the link ram,
// req is stalled meanwhile, register writes are taken as ever.
// a stalled rsp holds the walk; req is stalled until the last result is loaded for output
`default_nettype none
module aging_lru_dirty_line_cleaner (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output      logic                         req_stall,
	input  wire alc_pkg::req_t                req,
	output      logic                         rsp_valid,
	input  wire logic                         rsp_stall,
	output      alc_pkg::rsp_t                rsp,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [alc_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                  pwdata,
	output      logic [31:0]                  prdata,
	output      logic                         pready
);
	localparam int WORD_W = $bits(alc_pkg::link_word_t);

	alc_pkg::state_t state_q, state_d;

	logic [11:0] wakeup_q;
	logic [11:0] stale_q;
	logic [6:0]  limit_cfg_q;
	logic [19:0] activity_q;
	logic [31:0] last_clean_q;

	alc_pkg::req_t     req_q;
	alc_pkg::link_word_t lw_q;
	alc_pkg::rsp_t     out_q, pend_q;
	logic              ovalid_q, pend_v_q;
	logic [alc_pkg::LINE_W-1:0] clr_q;
	logic [alc_pkg::LINK_W-1:0] c_q, h_q;
	logic [alc_pkg::PCNT_W-1:0] q_q;
	logic [alc_pkg::LIM_W-1:0]  k_q, lim_q;
	logic [31:0] diff_q, cutoff_q;

	logic ram_we, ram_re;
	logic [alc_pkg::LINE_W-1:0] ram_addr;
	alc_pkg::link_word_t ram_wdata, rd;
	logic [WORD_W-1:0] ram_rdata;
	alc_pkg::list_cmd_t lcmd;
	logic [alc_pkg::LINK_W-1:0] l_head, l_tail;
	logic [31:0] alu_a, alu_b, alu_diff;
	logic alu_lt;

	logic out_free, wr_en, listed, bad_item, aged, q_end, k_full, op_set, out_load;
	logic [alc_pkg::LINK_W-1:0] line_link;
	logic [alc_pkg::PIDX_W-1:0] pin, qi;

	alc_ram #(.WIDTH(WORD_W), .DEPTH(alc_pkg::LINES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	alc_list_regs u_lists (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lcmd),
		.head   (l_head),
		.tail   (l_tail)
	);

	alc_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.lt   (alu_lt)
	);

	assign rd        = alc_pkg::link_word_t'(ram_rdata);
	assign out_free  = !ovalid_q || !rsp_stall;
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign req_stall = (state_q != alc_pkg::S_IDLE);
	assign rsp_valid = ovalid_q;
	assign rsp       = out_q;
	assign line_link = {1'b0, req_q.line[alc_pkg::LINE_W-1:0]};
	assign pin       = req_q.partition[alc_pkg::PIDX_W-1:0];
	assign qi        = q_q[alc_pkg::PIDX_W-1:0];
	assign op_set    = (req_q.operation == alc_pkg::OP_SET_HOT);
	assign bad_item  = (req_q.operation == alc_pkg::OP_RSVD) ||
		(32'(req_q.line) >= alc_pkg::LINES) || (32'(req_q.partition) >= alc_pkg::PARTS);
	assign listed    = (32'(rd.owner) < alc_pkg::PARTS) && ((rd.next != alc_pkg::TERM) ||
		(rd.prev != alc_pkg::TERM) || (l_head == line_link));
	assign aged      = alu_lt;
	assign q_end     = (32'(q_q) >= alc_pkg::PARTS);
	assign k_full    = ((k_q + 1'b1) == lim_q);
	assign out_load  = ((state_q == alc_pkg::S_WALK_CHK) && aged && pend_v_q && out_free) ||
		((state_q == alc_pkg::S_FINISH) && out_free);

	always_comb begin
		unique case (paddr[3:2])
			alc_pkg::REG_WAKEUP:    prdata = {20'b0, wakeup_q};
			alc_pkg::REG_STALENESS: prdata = {20'b0, stale_q};
			alc_pkg::REG_LIMIT:     prdata = {25'b0, limit_cfg_q};
			alc_pkg::REG_ACTIVITY:  prdata = {12'b0, activity_q};
			default:                prdata = '0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			alc_pkg::S_CLEAR: begin
				if (clr_q == alc_pkg::LINE_W'(alc_pkg::LINES - 1)) state_d = alc_pkg::S_IDLE;
			end
			alc_pkg::S_IDLE: begin
				if (req_valid) state_d = alc_pkg::S_DISPATCH;
			end
			alc_pkg::S_DISPATCH: begin
				if (req_q.operation == alc_pkg::OP_COLLECT) begin
					state_d = alu_lt ? alc_pkg::S_FINISH : alc_pkg::S_GATE_WAKE;
				end else if (bad_item) begin
					state_d = alc_pkg::S_FINISH;
				end else begin
					state_d = alc_pkg::S_CHK;
				end
			end
			alc_pkg::S_CHK: begin
				if (listed) state_d = alc_pkg::S_UL_PR;
				else if (op_set) state_d = alc_pkg::S_INS_L;
				else state_d = alc_pkg::S_FINISH;
			end
			alc_pkg::S_UL_PR: begin
				state_d = (lw_q.prev != alc_pkg::TERM) ? alc_pkg::S_UL_PW : alc_pkg::S_UL_NR;
			end
			alc_pkg::S_UL_PW: state_d = alc_pkg::S_UL_NR;
			alc_pkg::S_UL_NR: begin
				state_d = (lw_q.next != alc_pkg::TERM) ? alc_pkg::S_UL_NW : alc_pkg::S_UL_FIN;
			end
			alc_pkg::S_UL_NW: state_d = alc_pkg::S_UL_FIN;
			alc_pkg::S_UL_FIN: state_d = op_set ? alc_pkg::S_INS_L : alc_pkg::S_FINISH;
			alc_pkg::S_INS_L: begin
				state_d = (l_head != alc_pkg::TERM) ? alc_pkg::S_INS_HR : alc_pkg::S_FINISH;
			end
			alc_pkg::S_INS_HR: state_d = alc_pkg::S_INS_HW;
			alc_pkg::S_INS_HW: state_d = alc_pkg::S_FINISH;
			alc_pkg::S_GATE_WAKE: state_d = alc_pkg::S_GATE_CMP;
			alc_pkg::S_GATE_CMP: begin
				state_d = (!alu_lt || limit_cfg_q == '0) ? alc_pkg::S_FINISH : alc_pkg::S_CUT;
			end
			alc_pkg::S_CUT: state_d = alc_pkg::S_WALK_T;
			alc_pkg::S_WALK_T: begin
				if (q_end) state_d = alc_pkg::S_FINISH;
				else if (l_tail != alc_pkg::TERM) state_d = alc_pkg::S_WALK_RD;
			end
			alc_pkg::S_WALK_RD: state_d = alc_pkg::S_WALK_CHK;
			alc_pkg::S_WALK_CHK: begin
				if (!aged) begin
					state_d = alc_pkg::S_WALK_T;
				end else if (!pend_v_q || out_free) begin
					if (k_full) state_d = alc_pkg::S_FINISH;
					else if (rd.prev == alc_pkg::TERM) state_d = alc_pkg::S_WALK_T;
					else state_d = alc_pkg::S_WALK_RD;
				end
			end
			alc_pkg::S_FINISH: begin
				if (out_free) state_d = alc_pkg::S_IDLE;
			end
			default: state_d = alc_pkg::S_IDLE;
		endcase
	end

	// ram, list and alu control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = req_q.line[alc_pkg::LINE_W-1:0];
		ram_wdata = rd;
		lcmd      = '0;
		lcmd.idx  = lw_q.owner;
		lcmd.val  = line_link;
		alu_a     = req_q.idle_ms;
		alu_b     = {12'b0, activity_q};
		unique case (state_q)
			alc_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '{owner: '0, next: alc_pkg::TERM, prev: alc_pkg::TERM, stamp: '0};
			end
			alc_pkg::S_DISPATCH: begin
				ram_re = 1'b1;
			end
			alc_pkg::S_CHK: begin
				lcmd.idx = rd.owner;
			end
			alc_pkg::S_UL_PR: begin
				if (lw_q.prev != alc_pkg::TERM) begin
					ram_re   = 1'b1;
					ram_addr = lw_q.prev[alc_pkg::LINE_W-1:0];
				end else begin
					lcmd.head_we = 1'b1;
					lcmd.val     = lw_q.next;
				end
			end
			alc_pkg::S_UL_PW: begin
				ram_we         = 1'b1;
				ram_addr       = lw_q.prev[alc_pkg::LINE_W-1:0];
				ram_wdata.next = lw_q.next;
			end
			alc_pkg::S_UL_NR: begin
				if (lw_q.next != alc_pkg::TERM) begin
					ram_re   = 1'b1;
					ram_addr = lw_q.next[alc_pkg::LINE_W-1:0];
				end else begin
					lcmd.tail_we = 1'b1;
					lcmd.val     = lw_q.prev;
				end
			end
			alc_pkg::S_UL_NW: begin
				ram_we         = 1'b1;
				ram_addr       = lw_q.next[alc_pkg::LINE_W-1:0];
				ram_wdata.prev = lw_q.prev;
			end
			alc_pkg::S_UL_FIN: begin
				lcmd.dec  = 1'b1;
				ram_we    = 1'b1;
				ram_wdata = '{owner: lw_q.owner, next: alc_pkg::TERM, prev: alc_pkg::TERM,
					stamp: lw_q.stamp};
			end
			alc_pkg::S_INS_L: begin
				lcmd.idx     = pin;
				lcmd.head_we = 1'b1;
				lcmd.tail_we = (l_head == alc_pkg::TERM);
				lcmd.inc     = 1'b1;
				ram_we       = 1'b1;
				ram_wdata    = '{owner: pin, next: l_head, prev: alc_pkg::TERM,
					stamp: req_q.now_seconds};
			end
			alc_pkg::S_INS_HR: begin
				ram_re   = 1'b1;
				ram_addr = h_q[alc_pkg::LINE_W-1:0];
			end
			alc_pkg::S_INS_HW: begin
				ram_we         = 1'b1;
				ram_addr       = h_q[alc_pkg::LINE_W-1:0];
				ram_wdata.prev = line_link;
			end
			alc_pkg::S_GATE_WAKE: begin
				alu_a = req_q.now_seconds;
				alu_b = last_clean_q;
			end
			alc_pkg::S_GATE_CMP: begin
				alu_a = {20'b0, wakeup_q};
				alu_b = diff_q;
			end
			alc_pkg::S_CUT: begin
				alu_a = req_q.now_seconds;
				alu_b = {20'b0, stale_q};
			end
			alc_pkg::S_WALK_T: begin
				lcmd.idx = qi;
			end
			alc_pkg::S_WALK_RD: begin
				ram_re   = 1'b1;
				ram_addr = c_q[alc_pkg::LINE_W-1:0];
			end
			alc_pkg::S_WALK_CHK: begin
				alu_a = rd.stamp;
				alu_b = cutoff_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= alc_pkg::S_CLEAR;
			clr_q        <= '0;
			ovalid_q     <= 1'b0;
			pend_v_q     <= 1'b0;
			wakeup_q     <= 12'd20;
			stale_q      <= 12'd120;
			limit_cfg_q  <= 7'd64;
			activity_q   <= 20'd10000;
			last_clean_q <= '0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (paddr[3:2])
					alc_pkg::REG_WAKEUP:    wakeup_q    <= pwdata[11:0];
					alc_pkg::REG_STALENESS: stale_q     <= pwdata[11:0];
					alc_pkg::REG_LIMIT:     limit_cfg_q <= pwdata[6:0];
					alc_pkg::REG_ACTIVITY:  activity_q  <= pwdata[19:0];
					default: begin
					end
				endcase
			end
			if (out_load) ovalid_q <= 1'b1;
			else if (ovalid_q && !rsp_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				alc_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				alc_pkg::S_IDLE: pend_v_q <= 1'b0;
				alc_pkg::S_DISPATCH: begin
					if (req_q.operation == alc_pkg::OP_COLLECT) begin
						if (alu_lt) pend_v_q <= 1'b1;
					end else if (bad_item) begin
						pend_v_q <= 1'b1;
					end
				end
				alc_pkg::S_CHK: begin
					if (!listed && !op_set) pend_v_q <= 1'b1;
				end
				alc_pkg::S_UL_FIN: begin
					if (!op_set) pend_v_q <= 1'b1;
				end
				alc_pkg::S_INS_L: begin
					if (l_head == alc_pkg::TERM) pend_v_q <= 1'b1;
				end
				alc_pkg::S_INS_HW: pend_v_q <= 1'b1;
				alc_pkg::S_GATE_CMP: begin
					if (!alu_lt || limit_cfg_q == '0) pend_v_q <= 1'b1;
				end
				alc_pkg::S_WALK_CHK: begin
					if (aged && (!pend_v_q || out_free)) pend_v_q <= 1'b1;
				end
				alc_pkg::S_FINISH: begin
					if (out_free && !pend_v_q) last_clean_q <= req_q.now_seconds;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			alc_pkg::S_IDLE: begin
				if (req_valid) req_q <= req;
			end
			alc_pkg::S_DISPATCH: begin
				pend_q <= '{status: (req_q.operation == alc_pkg::OP_COLLECT) ?
					alc_pkg::ST_IO_BUSY : alc_pkg::ST_NOT_LISTED,
					flush_line: '0, flush_partition: '0, last: 1'b0};
			end
			alc_pkg::S_CHK: lw_q <= rd;
			alc_pkg::S_UL_FIN: begin
				pend_q.status <= alc_pkg::ST_REMOVED;
			end
			alc_pkg::S_INS_L: begin
				h_q           <= l_head;
				pend_q.status <= alc_pkg::ST_INSERTED;
			end
			alc_pkg::S_GATE_WAKE: diff_q <= alu_diff;
			alc_pkg::S_GATE_CMP: begin
				pend_q.status <= !alu_lt ? alc_pkg::ST_TOO_SOON : alc_pkg::ST_DISABLED;
				lim_q <= (limit_cfg_q > alc_pkg::LIM_W'(alc_pkg::MAX_EMIT)) ?
					alc_pkg::LIM_W'(alc_pkg::MAX_EMIT) : limit_cfg_q;
			end
			alc_pkg::S_CUT: begin
				cutoff_q <= alu_diff;
				q_q      <= '0;
				k_q      <= '0;
			end
			alc_pkg::S_WALK_T: begin
				c_q <= l_tail;
				if (!q_end && l_tail == alc_pkg::TERM) q_q <= q_q + 1'b1;
			end
			alc_pkg::S_WALK_CHK: begin
				if (!aged) begin
					q_q <= q_q + 1'b1;
				end else if (!pend_v_q || out_free) begin
					if (pend_v_q) out_q <= pend_q;
					pend_q <= '{status: alc_pkg::ST_FLUSH_LINE,
						flush_line: 12'(c_q[alc_pkg::LINE_W-1:0]),
						flush_partition: 5'(qi), last: 1'b0};
					k_q <= k_q + 1'b1;
					c_q <= rd.prev;
					if (rd.prev == alc_pkg::TERM) q_q <= q_q + 1'b1;
				end
			end
			alc_pkg::S_FINISH: begin
				if (out_free) begin
					if (pend_v_q) begin
						out_q <= '{status: pend_q.status, flush_line: pend_q.flush_line,
							flush_partition: pend_q.flush_partition, last: 1'b1};
					end else begin
						out_q <= '{status: alc_pkg::ST_NOTHING_AGED, flush_line: '0,
							flush_partition: '0, last: 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

[src/alc_checker.sv]
// alc_checker: port level assertions for the cleaner, bound to the top level
// depends on alc_pkg and aging_lru_dirty_line_cleaner
`default_nettype none
module alc_assertions (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire alc_pkg::rsp_t rsp,
	input wire logic          pready
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("ready right after a transfer");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != alc_pkg::ST_FLUSH_LINE |-> rsp.last)
		else $error("non flush result without last");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != alc_pkg::ST_FLUSH_LINE |->
		rsp.flush_line == '0 && rsp.flush_partition == '0)
		else $error("fields set on non flush result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind aging_lru_dirty_line_cleaner alc_assertions u_alc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp),
	.pready    (pready)
);
`default_nettype wire
